>>> sv/cbs_pkg.sv
// Shared types, constants and rounding helper for the cubic Bezier sampler.
`default_nettype none
package cbs_pkg;

  localparam int COORD_BITS = 24;   // Q8.16 coordinates
  localparam int T_W        = 17;   // Q0.16 parameter, 65536 = 1.0
  localparam int T_ONE      = 65536;
  localparam int T_EPS      = 7;    // 0.0001 in Q0.16
  localparam int SPS_W      = 7;
  localparam int CFG_IW     = 1;
  localparam int CFG_DW     = 17;
  localparam int SPS_RESET  = 16;
  localparam int STEP_RESET = 4096;

  localparam logic [CFG_IW-1:0] CFG_SAMPLES = 1'b0;
  localparam logic [CFG_IW-1:0] CFG_STEP    = 1'b1;

  localparam int SCL_W     = 31;    // scaled vector component: sign + 30 bit magnitude
  localparam int NORM_MSB  = 29;    // scaled max magnitude lies in [2^29, 2^30)
  localparam int UNIT_W    = 16;    // Q1.14
  localparam int UNIT_FRAC = 14;
  localparam int SQRT_BITS = 31;
  localparam int XW        = 2 * SQRT_BITS;
  localparam int QUO_BITS  = 15;
  localparam int PRE_LAT   = 3;
  localparam int UNIT_LAT  = PRE_LAT + 2 + SQRT_BITS + 1 + QUO_BITS;

  localparam int WIDE_W = 72;
  typedef logic signed [WIDE_W-1:0] wide_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] p0_x;
    logic signed [COORD_BITS-1:0] p0_y;
    logic signed [COORD_BITS-1:0] p0_z;
    logic signed [COORD_BITS-1:0] p1_x;
    logic signed [COORD_BITS-1:0] p1_y;
    logic signed [COORD_BITS-1:0] p1_z;
    logic signed [COORD_BITS-1:0] p2_x;
    logic signed [COORD_BITS-1:0] p2_y;
    logic signed [COORD_BITS-1:0] p2_z;
    logic signed [COORD_BITS-1:0] p3_x;
    logic signed [COORD_BITS-1:0] p3_y;
    logic signed [COORD_BITS-1:0] p3_z;
  } seg_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
    logic signed [UNIT_W-1:0]     tan_x;
    logic signed [UNIT_W-1:0]     tan_y;
    logic signed [UNIT_W-1:0]     tan_z;
    logic signed [UNIT_W-1:0]     nrm_x;
    logic signed [UNIT_W-1:0]     nrm_y;
    logic signed [UNIT_W-1:0]     nrm_z;
    logic                         degenerate;
    logic                         last_sample;
  } smp_t;

  // Shift right by s with rounding half away from zero (s is always a constant).
  function automatic wide_t rsr(input wide_t v, input int unsigned s);
    logic [WIDE_W-1:0] mag;
    mag = v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
    mag = (mag + (WIDE_W'(1) << (s - 1))) >> s;
    return v[WIDE_W-1] ? -wide_t'(mag) : wide_t'(mag);
  endfunction

endpackage
`default_nettype wire

>>> sv/cbs_prescale.sv
// Power-of-two prescale of a 3D vector so its largest magnitude sits in [2^29, 2^30).
`default_nettype none
module cbs_prescale #(
  parameter int W = 45
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [W-1:0]              vx,
  input  logic signed [W-1:0]              vy,
  input  logic signed [W-1:0]              vz,
  output logic signed [cbs_pkg::SCL_W-1:0] sx,
  output logic signed [cbs_pkg::SCL_W-1:0] sy,
  output logic signed [cbs_pkg::SCL_W-1:0] sz,
  output logic                             ok
);
  import cbs_pkg::*;

  localparam int PW = $clog2(W);
  localparam int MW = SCL_W - 1;

  logic signed [W-1:0] v [3];
  logic [W-1:0]        mc [3];
  logic [W-1:0]        ma [3];
  logic [2:0]          sa;
  logic [W-1:0]        oa;
  logic [W-1:0]        mb [3];
  logic [2:0]          sb;
  logic [PW-1:0]       lead_c;
  logic [PW-1:0]       lead_b;
  logic                nz_b;
  logic [W+MW-1:0]     shf [3];
  logic signed [SCL_W-1:0] sc [3];

  assign v[0] = vx;
  assign v[1] = vy;
  assign v[2] = vz;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mc[i] = v[i][W-1] ? W'(-v[i]) : W'(v[i]);
    end
  end

  // stage A: magnitudes; OR of magnitudes has the same top bit as their max
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ma[i] <= mc[i];
        sa[i] <= v[i][W-1];
      end
      oa <= mc[0] | mc[1] | mc[2];
    end
  end

  always_comb begin
    lead_c = '0;
    for (int i = 0; i < W; i++) begin
      if (oa[i]) begin
        lead_c = PW'(i);
      end
    end
  end

  // stage B: leading one position
  always_ff @(posedge clk) begin
    if (en) begin
      mb     <= ma;
      sb     <= sa;
      lead_b <= lead_c;
      nz_b   <= |oa;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (lead_b >= PW'(NORM_MSB)) begin
        shf[i] = (W+MW)'(mb[i]) >> (lead_b - PW'(NORM_MSB));
      end else begin
        shf[i] = (W+MW)'(mb[i]) << (PW'(NORM_MSB) - lead_b);
      end
    end
  end

  // stage C: shifted magnitudes with sign restored
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sc[i] <= sb[i] ? -SCL_W'(shf[i][MW-1:0]) : SCL_W'(shf[i][MW-1:0]);
      end
      ok <= nz_b;
    end
  end

  assign sx = sc[0];
  assign sy = sc[1];
  assign sz = sc[2];

endmodule
`default_nettype wire

>>> sv/cbs_unit.sv
// Pipelined normalize to Q1.14: prescale, sum of squares, bitwise sqrt, bitwise divide.
`default_nettype none
module cbs_unit #(
  parameter int W = 45
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [W-1:0]               vx,
  input  logic signed [W-1:0]               vy,
  input  logic signed [W-1:0]               vz,
  output logic signed [cbs_pkg::UNIT_W-1:0] ux,
  output logic signed [cbs_pkg::UNIT_W-1:0] uy,
  output logic signed [cbs_pkg::UNIT_W-1:0] uz,
  output logic                              ok
);
  import cbs_pkg::*;

  localparam int MW = SCL_W - 1;
  localparam int NW = MW + UNIT_FRAC + 1;

  logic signed [SCL_W-1:0] sv [3];
  logic                    pok;
  logic [MW-1:0]           sm [3];

  cbs_prescale #(.W(W)) u_pre (
    .clk (clk),
    .en  (en),
    .vx  (vx),
    .vy  (vy),
    .vz  (vz),
    .sx  (sv[0]),
    .sy  (sv[1]),
    .sz  (sv[2]),
    .ok  (pok)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sm[i] = sv[i][SCL_W-1] ? MW'(-sv[i]) : MW'(sv[i]);
    end
  end

  // squares
  logic [2*MW-1:0] sq_q [3];
  logic [3*MW-1:0] m_q;
  logic [2:0]      sg_q;
  logic            ok_q;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= sm[i] * sm[i];
        sg_q[i] <= sv[i][SCL_W-1];
      end
      m_q  <= {sm[2], sm[1], sm[0]};
      ok_q <= pok;
    end
  end

  // sum of squares
  logic [XW-1:0]   x_s;
  logic [3*MW-1:0] m_s;
  logic [2:0]      sg_s;
  logic            ok_s;

  always_ff @(posedge clk) begin
    if (en) begin
      x_s  <= XW'(sq_q[0]) + XW'(sq_q[1]) + XW'(sq_q[2]);
      m_s  <= m_q;
      sg_s <= sg_q;
      ok_s <= ok_q;
    end
  end

  // floor square root, one result bit per stage
  logic [XW-1:0]        rt_rem  [SQRT_BITS];
  logic [SQRT_BITS-1:0] rt_root [SQRT_BITS];
  logic [3*MW-1:0]      rt_m    [SQRT_BITS];
  logic [2:0]           rt_sg   [SQRT_BITS];
  logic                 rt_ok   [SQRT_BITS];

  for (genvar k = 0; k < SQRT_BITS; k++) begin : g_sqrt
    localparam int B = SQRT_BITS - 1 - k;
    logic [XW-1:0]        r_in;
    logic [SQRT_BITS-1:0] q_in;
    logic [3*MW-1:0]      m_in;
    logic [2:0]           sg_in;
    logic                 ok_in;
    logic [XW-1:0]        trial;

    if (k == 0) begin : g_head
      assign r_in  = x_s;
      assign q_in  = '0;
      assign m_in  = m_s;
      assign sg_in = sg_s;
      assign ok_in = ok_s;
    end else begin : g_body
      assign r_in  = rt_rem[k-1];
      assign q_in  = rt_root[k-1];
      assign m_in  = rt_m[k-1];
      assign sg_in = rt_sg[k-1];
      assign ok_in = rt_ok[k-1];
    end

    assign trial = (XW'(q_in) << (B + 1)) | (XW'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (en) begin
        if (r_in >= trial) begin
          rt_rem[k]  <= r_in - trial;
          rt_root[k] <= q_in | (SQRT_BITS'(1) << B);
        end else begin
          rt_rem[k]  <= r_in;
          rt_root[k] <= q_in;
        end
        rt_m[k]  <= m_in;
        rt_sg[k] <= sg_in;
        rt_ok[k] <= ok_in;
      end
    end
  end

  // dividend prep: m * 2^14 + len / 2
  logic [NW-1:0]        pr_num [3];
  logic [SQRT_BITS-1:0] pr_len;
  logic [2:0]           pr_sg;
  logic                 pr_ok;
  logic [SQRT_BITS-1:0] len_f;
  logic [3*MW-1:0]      m_f;

  assign len_f = rt_root[SQRT_BITS-1];
  assign m_f   = rt_m[SQRT_BITS-1];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pr_num[i] <= (NW'(m_f[i*MW +: MW]) << UNIT_FRAC) + NW'(len_f >> 1);
      end
      pr_len <= len_f;
      pr_sg  <= rt_sg[SQRT_BITS-1];
      pr_ok  <= rt_ok[SQRT_BITS-1];
    end
  end

  // restoring divide, one quotient bit per stage, three lanes
  logic [NW-1:0]        dv_rem [QUO_BITS][3];
  logic [QUO_BITS-1:0]  dv_q   [QUO_BITS][3];
  logic [SQRT_BITS-1:0] dv_len [QUO_BITS];
  logic [2:0]           dv_sg  [QUO_BITS];
  logic                 dv_ok  [QUO_BITS];

  for (genvar j = 0; j < QUO_BITS; j++) begin : g_div
    localparam int B = QUO_BITS - 1 - j;
    logic [NW-1:0]        r_in [3];
    logic [QUO_BITS-1:0]  q_in [3];
    logic [SQRT_BITS-1:0] l_in;
    logic [2:0]           sg_in;
    logic                 ok_in;
    logic [NW-1:0]        dsh;

    if (j == 0) begin : g_head
      assign r_in  = pr_num;
      assign q_in  = '{default: '0};
      assign l_in  = pr_len;
      assign sg_in = pr_sg;
      assign ok_in = pr_ok;
    end else begin : g_body
      assign r_in  = dv_rem[j-1];
      assign q_in  = dv_q[j-1];
      assign l_in  = dv_len[j-1];
      assign sg_in = dv_sg[j-1];
      assign ok_in = dv_ok[j-1];
    end

    assign dsh = NW'(l_in) << B;

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (r_in[i] >= dsh) begin
            dv_rem[j][i] <= r_in[i] - dsh;
            dv_q[j][i]   <= q_in[i] | (QUO_BITS'(1) << B);
          end else begin
            dv_rem[j][i] <= r_in[i];
            dv_q[j][i]   <= q_in[i];
          end
        end
        dv_len[j] <= l_in;
        dv_sg[j]  <= sg_in;
        dv_ok[j]  <= ok_in;
      end
    end
  end

  logic signed [UNIT_W-1:0] uo [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!dv_ok[QUO_BITS-1]) begin
        uo[i] = '0;
      end else if (dv_sg[QUO_BITS-1][i]) begin
        uo[i] = -UNIT_W'(dv_q[QUO_BITS-1][i]);
      end else begin
        uo[i] = UNIT_W'(dv_q[QUO_BITS-1][i]);
      end
    end
  end

  assign ux = uo[0];
  assign uy = uo[1];
  assign uz = uo[2];
  assign ok = dv_ok[QUO_BITS-1];

endmodule
`default_nettype wire

>>> sv/cubic_bezier_sampler_top.sv
// Cubic Bezier sampler: one segment in, a run of position/tangent/normal samples out.
//
// A segment (four Q8.16 control points) is taken on the seg channel and held.
// A sequencer then issues samples_per_segment parameter values t = 0, t_step,
// 2*t_step ... (clamped at 1.0) into a 68-stage pipeline (output register
// included), one per cycle while smp_stall is low, and the results leave on the
// smp channel in order, the final one marked with last_sample. Per sample:
// Bernstein position (Q8.16, saturated), unit tangent and unit normal (Q1.14),
// and a degenerate flag when any vector to be normalized was zero (its unit
// result then reads zero). A count of zero gives one sample; counts above
// MAX_SAMPLES are cut to MAX_SAMPLES.
// Rate: seg_stall stays high from a segment transfer until its last sample
// transfers. Samples stream at one per cycle when smp_stall stays low. The
// latency is set by the two normalize units (31 square-root stages and 15
// divide stages each) behind the derivative, prescale and cross-product
// stages. When smp_stall holds a valid sample, the whole pipeline and the
// sequencer freeze.
// Configuration: cfg_we with cfg_index 0 writes samples_per_segment, 1 writes
// t_step (Q0.16); write only while no segment is in flight.
`default_nettype none
module cubic_bezier_sampler_top #(
  parameter int MAX_SAMPLES = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          seg_valid,
  output logic                          seg_stall,
  input  cbs_pkg::seg_t                 seg,
  output logic                          smp_valid,
  input  logic                          smp_stall,
  output cbs_pkg::smp_t                 smp,
  input  logic                          cfg_we,
  input  logic [cbs_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [cbs_pkg::CFG_DW-1:0]    cfg_data
);
  import cbs_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int DW    = CB + 21;          // derivative width
  localparam int CW    = SCL_W;
  localparam int CRW   = 2 * SCL_W + 1;    // cross product width
  localparam int CNTW  = $clog2(MAX_SAMPLES + 1);

  // pipeline levels, counted from the issue register
  localparam int LAT_D    = 4;                          // derivatives ready
  localparam int LAT_POS  = 5;                          // position ready
  localparam int LAT_DS   = LAT_D + PRE_LAT;            // scaled derivatives
  localparam int LAT_CS   = LAT_DS + 2 + PRE_LAT;       // scaled first cross
  localparam int LAT_NR   = LAT_CS + 2;                 // second cross
  localparam int LAT_END  = LAT_NR + UNIT_LAT;          // unit normal
  localparam int POS_DL   = LAT_END - LAT_POS;
  localparam int TAN_DL   = LAT_END - (LAT_D + UNIT_LAT);
  localparam int DS_DL    = LAT_CS - LAT_DS;
  localparam int OK_DL    = LAT_END - LAT_CS;

  localparam logic signed [17:0] TS_ONE = 18'(T_ONE);
  localparam logic signed [17:0] TS_EPS = 18'(T_EPS);
  localparam wide_t POS_HI = (wide_t'(1) <<< (CB - 1)) - wide_t'(1);
  localparam wide_t POS_LO = -POS_HI - wide_t'(1);

  // ---------------- configuration ----------------
  logic [SPS_W-1:0] sps;
  logic [T_W-1:0]   t_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      sps    <= SPS_W'(SPS_RESET);
      t_step <= T_W'(STEP_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SAMPLES: sps    <= cfg_data[SPS_W-1:0];
        CFG_STEP:    t_step <= cfg_data[T_W-1:0];
        default:     ;
      endcase
    end
  end

  // ---------------- segment intake and sequencer ----------------
  logic            busy;
  logic            active;
  logic [CNTW-1:0] cnt;
  logic [CNTW-1:0] n_smp;
  logic [CNTW-1:0] n_next;
  logic [T_W-1:0]  tcur;
  logic [T_W-1:0]  tcur_next;
  logic [T_W:0]    tsum;
  logic            seq_last;
  logic            seg_xfer;
  logic            smp_xfer;
  logic            adv;
  seg_t            held;

  assign seg_stall = busy;
  assign seg_xfer  = seg_valid && !busy;
  assign smp_xfer  = smp_valid && !smp_stall;
  assign adv       = !smp_valid || !smp_stall;

  always_comb begin
    if (sps == '0) begin
      n_next = CNTW'(1);
    end else if (int'(sps) > MAX_SAMPLES) begin
      n_next = CNTW'(MAX_SAMPLES);
    end else begin
      n_next = CNTW'(sps);
    end
    tsum = {1'b0, tcur} + {1'b0, t_step};
    tcur_next = (tsum > (T_W+1)'(T_ONE)) ? T_W'(T_ONE) : tsum[T_W-1:0];
    seq_last  = (CNTW'(cnt + 1'b1) == n_smp);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      active <= 1'b0;
    end else begin
      if (seg_xfer) begin
        busy   <= 1'b1;
        active <= 1'b1;
      end else begin
        if (adv && active && seq_last) begin
          active <= 1'b0;
        end
        if (smp_xfer && smp.last_sample) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (seg_xfer) begin
      held  <= seg;
      cnt   <= '0;
      tcur  <= '0;
      n_smp <= n_next;
    end else if (adv && active) begin
      cnt  <= CNTW'(cnt + 1'b1);
      tcur <= tcur_next;
    end
  end

  // ---------------- valid and last travel with the samples ----------------
  logic [LAT_END:0] vld;
  logic [LAT_END:0] lst;
  logic [T_W-1:0]   t0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      smp_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[LAT_END-1:0], active};
      smp_valid <= vld[LAT_END];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lst <= {lst[LAT_END-1:0], active && seq_last};
      t0  <= tcur;
    end
  end

  // control points as an array
  logic signed [CB-1:0] pt [4][3];
  assign pt[0][0] = held.p0_x;
  assign pt[0][1] = held.p0_y;
  assign pt[0][2] = held.p0_z;
  assign pt[1][0] = held.p1_x;
  assign pt[1][1] = held.p1_y;
  assign pt[1][2] = held.p1_z;
  assign pt[2][0] = held.p2_x;
  assign pt[2][1] = held.p2_y;
  assign pt[2][2] = held.p2_z;
  assign pt[3][0] = held.p3_x;
  assign pt[3][1] = held.p3_y;
  assign pt[3][2] = held.p3_z;

  // ---------------- S1: t, u products at t and t + eps ----------------
  logic signed [17:0] ts, us, te, ue;
  logic signed [17:0] t1, u1;
  logic signed [35:0] a_uu, a_tu, a_tt, b_uu, b_tu, b_tt;

  assign ts = 18'(t0);
  assign us = TS_ONE - ts;
  assign te = ts + TS_EPS;
  assign ue = TS_ONE - te;

  always_ff @(posedge clk) begin
    if (adv) begin
      t1   <= ts;
      u1   <= us;
      a_uu <= us * us;
      a_tu <= ts * us;
      a_tt <= ts * ts;
      b_uu <= ue * ue;
      b_tu <= te * ue;
      b_tt <= te * te;
    end
  end

  // ---------------- S2: derivative weights, cubic terms ----------------
  logic signed [17:0] wa [3];
  logic signed [17:0] wb [3];
  logic signed [53:0] c_u3, c_tu2, c_t2u, c_t3;

  always_ff @(posedge clk) begin
    if (adv) begin
      wa[0] <= 18'(rsr(wide_t'(a_uu), 16));
      wa[1] <= 18'(rsr(wide_t'(a_tu) <<< 1, 16));
      wa[2] <= 18'(rsr(wide_t'(a_tt), 16));
      wb[0] <= 18'(rsr(wide_t'(b_uu), 16));
      wb[1] <= 18'(rsr(wide_t'(b_tu) <<< 1, 16));
      wb[2] <= 18'(rsr(wide_t'(b_tt), 16));
      c_u3  <= a_uu * u1;
      c_tu2 <= a_tu * u1;
      c_t2u <= a_tt * u1;
      c_t3  <= a_tt * t1;
    end
  end

  // ---------------- S3: Bernstein weights, derivative products ----------------
  logic signed [31:0]   bw [4];
  logic signed [CB:0]   df [3][3];
  logic signed [CB+18:0] pa [3][3];
  logic signed [CB+18:0] pb [3][3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        df[j][k] = (CB+1)'(pt[j+1][k]) - (CB+1)'(pt[j][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bw[0] <= 32'(rsr(wide_t'(c_u3), 18));
      bw[1] <= 32'(rsr(wide_t'(c_tu2) + (wide_t'(c_tu2) <<< 1), 18));
      bw[2] <= 32'(rsr(wide_t'(c_t2u) + (wide_t'(c_t2u) <<< 1), 18));
      bw[3] <= 32'(rsr(wide_t'(c_t3), 18));
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          pa[k][j] <= df[j][k] * wa[j];
          pb[k][j] <= df[j][k] * wb[j];
        end
      end
    end
  end

  // ---------------- S4: derivative sums, position products ----------------
  logic signed [DW-1:0]   da [3];
  logic signed [DW-1:0]   db [3];
  logic signed [CB+31:0]  pp [3][4];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        da[k] <= DW'(pa[k][0]) + DW'(pa[k][1]) + DW'(pa[k][2]);
        db[k] <= DW'(pb[k][0]) + DW'(pb[k][1]) + DW'(pb[k][2]);
        for (int j = 0; j < 4; j++) begin
          pp[k][j] <= pt[j][k] * bw[j];
        end
      end
    end
  end

  // ---------------- S5: position round and saturate ----------------
  wide_t                psum [3];
  logic signed [CB-1:0] pos5 [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      psum[k] = rsr(wide_t'(pp[k][0]) + wide_t'(pp[k][1]) + wide_t'(pp[k][2]) +
                    wide_t'(pp[k][3]), 30);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        if (psum[k] > POS_HI) begin
          pos5[k] <= CB'(POS_HI);
        end else if (psum[k] < POS_LO) begin
          pos5[k] <= CB'(POS_LO);
        end else begin
          pos5[k] <= CB'(psum[k]);
        end
      end
    end
  end

  logic [3*CB-1:0] pos_dl [POS_DL];

  always_ff @(posedge clk) begin
    if (adv) begin
      pos_dl[0] <= {pos5[2], pos5[1], pos5[0]};
      for (int i = 1; i < POS_DL; i++) begin
        pos_dl[i] <= pos_dl[i-1];
      end
    end
  end

  // ---------------- tangent ----------------
  logic signed [UNIT_W-1:0] tan_u [3];
  logic                     ok_tan;
  logic [3*UNIT_W:0]        tan_dl [TAN_DL];

  cbs_unit #(.W(DW)) u_tan (
    .clk (clk),
    .en  (adv),
    .vx  (da[0]),
    .vy  (da[1]),
    .vz  (da[2]),
    .ux  (tan_u[0]),
    .uy  (tan_u[1]),
    .uz  (tan_u[2]),
    .ok  (ok_tan)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      tan_dl[0] <= {ok_tan, tan_u[2], tan_u[1], tan_u[0]};
      for (int i = 1; i < TAN_DL; i++) begin
        tan_dl[i] <= tan_dl[i-1];
      end
    end
  end

  // ---------------- normal: scale, cross, scale, cross, normalize ----------------
  logic signed [CW-1:0] ds  [3];
  logic signed [CW-1:0] d2s [3];
  logic                 ok_ds, ok_d2s;

  cbs_prescale #(.W(DW)) u_pre_d (
    .clk (clk),
    .en  (adv),
    .vx  (da[0]),
    .vy  (da[1]),
    .vz  (da[2]),
    .sx  (ds[0]),
    .sy  (ds[1]),
    .sz  (ds[2]),
    .ok  (ok_ds)
  );

  cbs_prescale #(.W(DW)) u_pre_d2 (
    .clk (clk),
    .en  (adv),
    .vx  (db[0]),
    .vy  (db[1]),
    .vz  (db[2]),
    .sx  (d2s[0]),
    .sy  (d2s[1]),
    .sz  (d2s[2]),
    .ok  (ok_d2s)
  );

  // first cross: d2s x ds
  logic signed [2*CW-1:0] c1p [6];
  logic signed [CRW-1:0]  cr  [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      c1p[0] <= d2s[1] * ds[2];
      c1p[1] <= d2s[2] * ds[1];
      c1p[2] <= d2s[2] * ds[0];
      c1p[3] <= d2s[0] * ds[2];
      c1p[4] <= d2s[0] * ds[1];
      c1p[5] <= d2s[1] * ds[0];
      cr[0]  <= CRW'(c1p[0]) - CRW'(c1p[1]);
      cr[1]  <= CRW'(c1p[2]) - CRW'(c1p[3]);
      cr[2]  <= CRW'(c1p[4]) - CRW'(c1p[5]);
    end
  end

  // scaled tangent direction held until the scaled first cross is ready
  logic [3*CW:0] ds_dl [DS_DL];

  always_ff @(posedge clk) begin
    if (adv) begin
      ds_dl[0] <= {ok_ds && ok_d2s, ds[2], ds[1], ds[0]};
      for (int i = 1; i < DS_DL; i++) begin
        ds_dl[i] <= ds_dl[i-1];
      end
    end
  end

  logic signed [CW-1:0] cs  [3];
  logic signed [CW-1:0] dsd [3];
  logic                 ok_cs;

  cbs_prescale #(.W(CRW)) u_pre_c (
    .clk (clk),
    .en  (adv),
    .vx  (cr[0]),
    .vy  (cr[1]),
    .vz  (cr[2]),
    .sx  (cs[0]),
    .sy  (cs[1]),
    .sz  (cs[2]),
    .ok  (ok_cs)
  );

  assign dsd[0] = ds_dl[DS_DL-1][CW-1:0];
  assign dsd[1] = ds_dl[DS_DL-1][2*CW-1:CW];
  assign dsd[2] = ds_dl[DS_DL-1][3*CW-1:2*CW];

  // second cross: cs x ds
  logic signed [2*CW-1:0] c2p [6];
  logic signed [CRW-1:0]  nr  [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      c2p[0] <= cs[1] * dsd[2];
      c2p[1] <= cs[2] * dsd[1];
      c2p[2] <= cs[2] * dsd[0];
      c2p[3] <= cs[0] * dsd[2];
      c2p[4] <= cs[0] * dsd[1];
      c2p[5] <= cs[1] * dsd[0];
      nr[0]  <= CRW'(c2p[0]) - CRW'(c2p[1]);
      nr[1]  <= CRW'(c2p[2]) - CRW'(c2p[3]);
      nr[2]  <= CRW'(c2p[4]) - CRW'(c2p[5]);
    end
  end

  // validity of the scaled derivatives and first cross, aligned to the normal
  logic [OK_DL-1:0] ok_dl;

  always_ff @(posedge clk) begin
    if (adv) begin
      ok_dl <= {ok_dl[OK_DL-2:0], ds_dl[DS_DL-1][3*CW] && ok_cs};
    end
  end

  logic signed [UNIT_W-1:0] nrm_u [3];
  logic                     ok_nrm;

  cbs_unit #(.W(CRW)) u_nrm (
    .clk (clk),
    .en  (adv),
    .vx  (nr[0]),
    .vy  (nr[1]),
    .vz  (nr[2]),
    .ux  (nrm_u[0]),
    .uy  (nrm_u[1]),
    .uz  (nrm_u[2]),
    .ok  (ok_nrm)
  );

  // ---------------- output register ----------------
  logic [3*UNIT_W:0] tan_f;
  logic [3*CB-1:0]   pos_f;

  assign tan_f = tan_dl[TAN_DL-1];
  assign pos_f = pos_dl[POS_DL-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      smp.pos_x       <= pos_f[CB-1:0];
      smp.pos_y       <= pos_f[2*CB-1:CB];
      smp.pos_z       <= pos_f[3*CB-1:2*CB];
      smp.tan_x       <= tan_f[UNIT_W-1:0];
      smp.tan_y       <= tan_f[2*UNIT_W-1:UNIT_W];
      smp.tan_z       <= tan_f[3*UNIT_W-1:2*UNIT_W];
      smp.nrm_x       <= nrm_u[0];
      smp.nrm_y       <= nrm_u[1];
      smp.nrm_z       <= nrm_u[2];
      smp.degenerate  <= !(tan_f[3*UNIT_W] && ok_dl[OK_DL-1] && ok_nrm);
      smp.last_sample <= lst[LAT_END];
    end
  end

endmodule
`default_nettype wire
